[rtl/core/limit_order_book_store_unit_assert.svh]
// Assertion macros for the order book store unit.
// Used by the checker module; no other dependencies.
`ifndef LIMIT_ORDER_BOOK_STORE_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_STORE_UNIT_ASSERT_SVH
`define LOB_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define LOB_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[rtl/core/lobs_pkg.sv]
// Package for the order book store: types, status and kind codes.
// No dependencies.
`default_nettype none
package lobs_pkg;
    localparam int ORDER_SLOTS_DEF = 1024;
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;
    localparam logic [1:0] KIND_POP = 2'd3;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_DUP = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_SUM, S_OUT
    } lobs_state_t;

    // Fields are listed from the highest bit down, so kind sits in the lowest bits.
    typedef struct packed {
        logic [31:0] quantity;
        logic [31:0] price;
        logic        side;
        logic [63:0] order_tag;
        logic [1:0]  kind;
    } lobs_req_t;

    // Fields are listed from the highest bit down, so status sits in the lowest bits.
    typedef struct packed {
        logic [32:0] spread_value;
        logic [31:0] best_ask;
        logic        ask_present;
        logic [31:0] best_bid;
        logic        bid_present;
        logic [2:0]  status;
    } lobs_rsp_t;
endpackage
`default_nettype wire

[rtl/core/lobs_scan.sv]
// Per-slot compare unit: one slot per cycle while en is high, tracks id match, free slot,
// oldest order and (second pass) best prices. Uses lobs_pkg.
`default_nettype none
module lobs_scan (
    input  wire logic              aclk,
    input  wire logic              clr,
    input  wire logic              en,
    input  wire logic              pass2,
    input  wire lobs_pkg::lobs_req_t req,
    input  wire logic [31:0]       next_seq,
    input  wire logic [15:0]       idx,
    input  wire logic              used,
    input  wire logic [63:0]       id,
    input  wire logic              side,
    input  wire logic [31:0]       price,
    input  wire logic [31:0]       seq,
    output logic                   id_hit_reg,
    output logic [15:0]            id_idx_reg,
    output logic                   free_hit_reg,
    output logic [15:0]            free_idx_reg,
    output logic                   old_hit_reg,
    output logic [15:0]            old_idx_reg,
    output logic                   bid_hit_reg,
    output logic [31:0]            bid_reg,
    output logic                   ask_hit_reg,
    output logic [31:0]            ask_reg
);
    import lobs_pkg::*;
    logic [31:0] age, age_reg;
    assign age = next_seq - seq;
    always_ff @(posedge aclk) begin
        if (clr) begin
            id_hit_reg <= 1'b0; free_hit_reg <= 1'b0; old_hit_reg <= 1'b0;
            bid_hit_reg <= 1'b0; ask_hit_reg <= 1'b0;
        end else if (en && !pass2) begin
            if (used && id == req.order_tag && !id_hit_reg) begin
                id_hit_reg <= 1'b1; id_idx_reg <= idx;
            end
            if (!used && !free_hit_reg) begin
                free_hit_reg <= 1'b1; free_idx_reg <= idx;
            end
            if (used && side == req.side && price == req.price &&
                (!old_hit_reg || age > age_reg)) begin
                old_hit_reg <= 1'b1; old_idx_reg <= idx; age_reg <= age;
            end
        end else if (en && used) begin
            if (!side && (!bid_hit_reg || price > bid_reg)) begin
                bid_hit_reg <= 1'b1; bid_reg <= price;
            end
            if (side && (!ask_hit_reg || price < ask_reg)) begin
                ask_hit_reg <= 1'b1; ask_reg <= price;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/limit_order_book_store_unit.sv]
// Order book store top level: slot memories, sequencer, output register.
// Uses lobs_pkg and lobs_scan.
//  channel | dir | tdata fields (low bit first)                               | tuser
//  s_      | in  | kind, order_tag, side, price, quantity                     | -
//  m_      | out | status, bid_present, best_bid, ask_pres, best_ask, spread | -
// s_tready stays low from the accepted input item until its result item is loaded into
// the output register, so one input item is handled at a time: one slot memory read port
// is swept once to search and once more to find the best prices.
// Reset clears slot valid bits by a pass over all slots; no item is
// accepted meanwhile. A result item waiting on m_tready holds the next item in
// its last state until the result is taken.
`default_nettype none
module limit_order_book_store_unit #(
    parameter int ORDER_SLOTS = lobs_pkg::ORDER_SLOTS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[1:0], order_tag[65:2], side[66], price[98:67], quantity[130:99]
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], bid_present[3], best_bid[35:4], ask_present[36],
    // best_ask[68:37], spread_value[101:69]
    output logic [103:0]      m_tdata
);
    import lobs_pkg::*;
    localparam int AW = $clog2(ORDER_SLOTS);

    logic        used_mem [ORDER_SLOTS];
    logic [63:0] id_mem   [ORDER_SLOTS];
    logic        side_mem [ORDER_SLOTS];
    logic [31:0] price_mem[ORDER_SLOTS];
    logic [31:0] qty_mem  [ORDER_SLOTS];
    logic [31:0] seq_mem  [ORDER_SLOTS];

    lobs_state_t state_reg, state_next;
    lobs_req_t   req_reg;
    lobs_rsp_t   rsp_reg;
    logic [2:0]  status_reg;
    logic [AW:0] cnt_reg;
    logic        init_reg, pass2_reg, rd_v_reg, m_valid_reg;
    logic [AW-1:0] rd_idx_reg, wr_a;
    logic [31:0] next_seq_reg;
    logic        r_used, r_side;
    logic [63:0] r_id;
    logic [31:0] r_price, r_seq, r_qty;
    logic        id_hit, free_hit, old_hit, bid_hit, ask_hit;
    logic [15:0] id_idx, free_idx, old_idx;
    logic [31:0] bid, ask;
    logic [2:0]  st;
    logic        wr_used_en, wr_used_v, wr_all, wr_qty;
    logic        rd_en, last, out_load;

    assign s_tready = (state_reg == S_IDLE) && !init_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {2'b0, rsp_reg};
    assign last = cnt_reg == (AW+1)'(ORDER_SLOTS - 1);
    assign rd_en = (state_reg == S_SCAN || state_reg == S_SUM) && !cnt_reg[AW];
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            r_used <= used_mem[cnt_reg[AW-1:0]];
            r_id <= id_mem[cnt_reg[AW-1:0]];
            r_side <= side_mem[cnt_reg[AW-1:0]];
            r_price <= price_mem[cnt_reg[AW-1:0]];
            r_seq <= seq_mem[cnt_reg[AW-1:0]];
        end
        r_qty <= qty_mem[old_idx[AW-1:0]];
    end

    lobs_scan u_scan (
        .aclk(aclk), .clr(state_reg == S_IDLE), .en(rd_v_reg), .pass2(pass2_reg),
        .req(req_reg), .next_seq(next_seq_reg), .idx(16'(rd_idx_reg)),
        .used(r_used), .id(r_id), .side(r_side), .price(r_price), .seq(r_seq),
        .id_hit_reg(id_hit), .id_idx_reg(id_idx), .free_hit_reg(free_hit),
        .free_idx_reg(free_idx), .old_hit_reg(old_hit), .old_idx_reg(old_idx),
        .bid_hit_reg(bid_hit), .bid_reg(bid), .ask_hit_reg(ask_hit), .ask_reg(ask)
    );

    always_comb begin
        st = ST_OK; wr_used_en = 1'b0; wr_used_v = 1'b0; wr_all = 1'b0;
        wr_qty = 1'b0; wr_a = old_idx[AW-1:0];
        unique case (req_reg.kind)
            KIND_ADD: begin
                wr_a = free_idx[AW-1:0];
                if (req_reg.quantity == 32'd0) st = ST_ZERO;
                else if (id_hit) st = ST_DUP;
                else if (!free_hit) st = ST_FULL;
                else begin
                    wr_used_en = 1'b1; wr_used_v = 1'b1; wr_all = 1'b1;
                end
            end
            KIND_CANCEL: begin
                wr_a = id_idx[AW-1:0];
                if (!id_hit) st = ST_NOT_FOUND;
                else wr_used_en = 1'b1;
            end
            KIND_REDUCE: begin
                if (!old_hit) st = ST_NOT_FOUND;
                else wr_qty = 1'b1;
            end
            default: begin
                if (!old_hit) st = ST_NOT_FOUND;
                else wr_used_en = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (init_reg) begin
            used_mem[cnt_reg[AW-1:0]] <= 1'b0;
        end else if (state_reg == S_APPLY) begin
            if (wr_used_en) used_mem[wr_a] <= wr_used_v;
            if (wr_all) begin
                id_mem[wr_a] <= req_reg.order_tag;
                side_mem[wr_a] <= req_reg.side;
                price_mem[wr_a] <= req_reg.price;
                qty_mem[wr_a] <= req_reg.quantity;
                seq_mem[wr_a] <= next_seq_reg;
            end
            if (wr_qty) begin
                qty_mem[wr_a] <= (r_qty > req_reg.quantity) ?
                    r_qty - req_reg.quantity : 32'd0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_SCAN;
            S_SCAN: if (cnt_reg[AW] && !rd_v_reg) state_next = S_APPLY;
            S_APPLY: state_next = S_SUM;
            S_SUM: if (cnt_reg[AW] && !rd_v_reg) state_next = S_OUT;
            S_OUT: if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; init_reg <= 1'b1; cnt_reg <= '0;
            m_valid_reg <= 1'b0; rd_v_reg <= 1'b0; next_seq_reg <= '0;
            pass2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg <= rd_en;
            rd_idx_reg <= cnt_reg[AW-1:0];
            m_valid_reg <= out_load || (m_valid_reg && !m_tready);
            if (init_reg) begin
                cnt_reg <= last ? '0 : cnt_reg + 1'b1;
                if (last) init_reg <= 1'b0;
            end else if (rd_en) begin
                cnt_reg <= last ? {1'b1, {AW{1'b0}}} : cnt_reg + 1'b1;
            end else if (state_reg == S_IDLE || state_reg == S_APPLY) begin
                cnt_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    pass2_reg <= 1'b0;
                    if (s_tvalid && s_tready) req_reg <= s_tdata[130:0];
                end
                S_APPLY: begin
                    pass2_reg <= 1'b1;
                    status_reg <= st;
                    if (wr_all) next_seq_reg <= next_seq_reg + 32'd1;
                end
                S_OUT: begin
                    if (out_load) begin
                        rsp_reg.status <= status_reg;
                        rsp_reg.bid_present <= bid_hit;
                        rsp_reg.best_bid <= bid_hit ? bid : 32'd0;
                        rsp_reg.ask_present <= ask_hit;
                        rsp_reg.best_ask <= ask_hit ? ask : 32'd0;
                        rsp_reg.spread_value <= (bid_hit && ask_hit) ?
                            {1'b0, ask} - {1'b0, bid} : 33'd0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/lobs_checker.sv]
// Port-level checker for the order book store unit, bound to the top.
// Uses limit_order_book_store_unit_assert.svh.
`default_nettype none
`include "limit_order_book_store_unit_assert.svh"
module lobs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);
    `LOB_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LOB_ASSERT_NXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LOB_ASSERT_IMP(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4)
    `LOB_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
endmodule
bind limit_order_book_store_unit lobs_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

[sim/limit_order_book_store_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for the order book store unit: drives add, cancel, reduce and pop items
// and checks every status and best-price item against a scoreboard. Uses lobs_pkg.
`default_nettype none
class book_scoreboard;
    localparam int NSLOT = lobs_pkg::ORDER_SLOTS_DEF;
    bit               used [NSLOT];
    logic [63:0]      id [NSLOT];
    logic             sd [NSLOT];
    logic [31:0]      px [NSLOT];
    logic [31:0]      qty [NSLOT];
    logic [31:0]      seq [NSLOT];
    logic [31:0]      next_seq;
    lobs_pkg::lobs_rsp_t pending [$];
    int               mismatches;

    function new();
        foreach (used[i]) used[i] = 0;
        next_seq = 0;
        mismatches = 0;
    endfunction

    function int find_id(logic [63:0] v);
        foreach (used[i]) if (used[i] && id[i] == v) return i;
        return -1;
    endfunction

    function int find_oldest(logic s, logic [31:0] p);
        int b;
        logic [31:0] ba, a;
        b = -1;
        ba = 0;
        foreach (used[i]) begin
            if (used[i] && sd[i] == s && px[i] == p) begin
                a = next_seq - seq[i];
                if (b < 0 || a > ba) begin
                    b = i;
                    ba = a;
                end
            end
        end
        return b;
    endfunction

    function void note_request(lobs_pkg::lobs_req_t r);
        lobs_pkg::lobs_rsp_t e;
        int s;
        e = '0;
        e.status = lobs_pkg::ST_OK;
        if (r.kind == lobs_pkg::KIND_ADD) begin
            if (r.quantity == 0) e.status = lobs_pkg::ST_ZERO;
            else if (find_id(r.order_tag) >= 0) e.status = lobs_pkg::ST_DUP;
            else begin
                s = -1;
                foreach (used[i]) if (!used[i] && s < 0) s = i;
                if (s < 0) e.status = lobs_pkg::ST_FULL;
                else begin
                    used[s] = 1; id[s] = r.order_tag; sd[s] = r.side;
                    px[s] = r.price; qty[s] = r.quantity; seq[s] = next_seq;
                    next_seq = next_seq + 1;
                end
            end
        end else if (r.kind == lobs_pkg::KIND_CANCEL) begin
            s = find_id(r.order_tag);
            if (s < 0) e.status = lobs_pkg::ST_NOT_FOUND;
            else used[s] = 0;
        end else begin
            s = find_oldest(r.side, r.price);
            if (s < 0) e.status = lobs_pkg::ST_NOT_FOUND;
            else if (r.kind == lobs_pkg::KIND_REDUCE)
                qty[s] = (qty[s] > r.quantity) ? qty[s] - r.quantity : 32'd0;
            else used[s] = 0;
        end
        foreach (used[i]) begin
            if (used[i]) begin
                if (sd[i] == 1'b0) begin
                    if (!e.bid_present || px[i] > e.best_bid) begin
                        e.best_bid = px[i];
                        e.bid_present = 1;
                    end
                end else if (!e.ask_present || px[i] < e.best_ask) begin
                    e.best_ask = px[i];
                    e.ask_present = 1;
                end
            end
        end
        if (e.bid_present && e.ask_present)
            e.spread_value = {1'b0, e.best_ask} - {1'b0, e.best_bid};
        pending.insert(pending.size(), e);
    endfunction

    function void check_result(lobs_pkg::lobs_rsp_t a);
        lobs_pkg::lobs_rsp_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", a);
            return;
        end
        e = pending[0];
        pending.delete(0);
        if (a.status !== e.status || a.bid_present !== e.bid_present
                || a.best_bid !== e.best_bid || a.ask_present !== e.ask_present
                || a.best_ask !== e.best_ask || a.spread_value !== e.spread_value) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: st %0d/%0d bid %0d:%0d/%0d:%0d ask %0d:%0d/%0d:%0d spr %0d/%0d",
                    e.status, a.status, e.bid_present, e.best_bid, a.bid_present, a.best_bid,
                    e.ask_present, e.best_ask, a.ask_present, a.best_ask,
                    e.spread_value, a.spread_value);
        end
    endfunction
endclass

module limit_order_book_store_unit_tb;
    import lobs_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    book_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    longint cycles;
    logic [63:0] used_ids [$];
    logic [31:0] used_prices [$];

    limit_order_book_store_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Each item sweeps all slots to search and again for prices; allow many times the slowest run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 64'd20_000_000) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(lobs_rsp_t'(m_tdata[101:0]));
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(lobs_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, r.quantity, r.price, r.side, r.order_tag, r.kind};
        do @(posedge aclk); while (!s_tready);
        board.note_request(r);
    endtask

    task automatic send_fields(logic [1:0] k, logic [63:0] oid, logic sd,
                               logic [31:0] p, logic [31:0] q);
        lobs_req_t r;
        r.kind = k; r.order_tag = oid; r.side = sd; r.price = p; r.quantity = q;
        send_item(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_id();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_random();
        int c;
        logic [63:0] oid;
        logic [31:0] p;
        logic [1:0] k;
        c = $urandom_range(99);
        p = (used_prices.size() > 0 && $urandom_range(3) != 0)
            ? used_prices[$urandom_range(used_prices.size() - 1)] : $urandom();
        oid = (used_ids.size() > 0 && $urandom_range(2) != 0)
            ? used_ids[$urandom_range(used_ids.size() - 1)] : rand_id();
        if (c < 45) begin
            k = KIND_ADD;
            if ($urandom_range(9) != 0) oid = rand_id();
            used_ids.insert(used_ids.size(), oid);
            if ($urandom_range(3) != 0) used_prices.insert(used_prices.size(), p);
        end else if (c < 60) k = KIND_CANCEL;
        else if (c < 80) k = KIND_REDUCE;
        else k = KIND_POP;
        send_fields(k, oid, 1'($urandom_range(1)), p,
                    ($urandom_range(9) == 0) ? 32'd0 : $urandom());
        if (used_ids.size() > 64) used_ids.delete(0);
        if (used_prices.size() > 32) used_prices.delete(0);
    endtask

    initial begin
        board = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        hold_off = 0;
        send_idle_pct = 33;
        recv_idle_pct = 66;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_fields(KIND_POP, 64'd1, 1'b0, 32'd5, 32'd1);
        send_fields(KIND_CANCEL, 64'd1, 1'b0, 32'd5, 32'd1);
        send_fields(KIND_ADD, 64'd1, 1'b0, 32'd5, 32'd0);
        send_fields(KIND_ADD, 64'd0, 1'b0, 32'd0, 32'd10);
        send_fields(KIND_ADD, '1, 1'b1, '1, '1);
        send_fields(KIND_ADD, 64'd7, 1'b0, '1, 32'd3);
        send_fields(KIND_ADD, 64'd7, 1'b1, 32'd1, 32'd3);
        send_fields(KIND_ADD, 64'd8, 1'b0, '1, 32'd9);
        send_fields(KIND_REDUCE, 64'd0, 1'b0, '1, 32'd1);
        send_fields(KIND_REDUCE, 64'd0, 1'b0, '1, '1);
        send_fields(KIND_POP, 64'd0, 1'b0, '1, 32'd0);
        send_fields(KIND_POP, 64'd0, 1'b0, '1, 32'd0);
        send_fields(KIND_REDUCE, 64'd0, 1'b1, 32'd1234, 32'd1);
        send_fields(KIND_ADD, 64'h5555_5555_5555_5555, 1'b1, 32'h8000_0000, 32'd1);
        send_fields(KIND_CANCEL, '1, 1'b0, 32'd0, 32'd0);
        send_fields(KIND_CANCEL, 64'd0, 1'b1, '1, '1);
        send_fields(KIND_CANCEL, 64'd0, 1'b1, '1, '1);
        send_fields(KIND_ADD, 64'd20, 1'b1, 32'd0, 32'd1);
        drain();

        // Receiver holds off while the sender keeps offering items.
        hold_off = 1;
        fork
            begin
                repeat (6000) @(posedge aclk);
                hold_off = 0;
            end
            begin
                repeat (4) send_random();
                s_tvalid <= 1'b0;
            end
        join
        drain();

        for (int n = 0; n < 556; n++) begin
            if (n == 185) begin
                send_idle_pct = 66;
                recv_idle_pct = 33;
            end
            if (n == 370) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 290) drain();
            send_random();
        end

        drain();
        repeat (2 * ORDER_SLOTS_DEF + 50) @(posedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
